/* rtl/prefix_expression_evaluator_defines.svh */
// ----------------------------------------------------------------------------
// Prefix expression evaluator assertion macros
// Shared property wrappers for the checker attached to the top level.
// ----------------------------------------------------------------------------
`ifndef PREFIX_EXPRESSION_EVALUATOR_DEFINES_SVH
`define PREFIX_EXPRESSION_EVALUATOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define PFX_ASSERT_IMPL(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("same-cycle implication failed");

// Next-cycle implication, disabled while reset is asserted
`define PFX_ASSERT_NEXT(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");

`endif

/* rtl/pfx_pkg.sv */
// ----------------------------------------------------------------------------
// Prefix expression evaluator package
// Character codes, status codes, ALU request types and state encodings.
// ----------------------------------------------------------------------------
package pfx_pkg;

    localparam int STACK_DEPTH_DEF = 64;
    localparam int WORD_W          = 32;
    localparam int SYM_W           = 8;
    localparam int STATUS_W        = 3;

    // Operator and digit character codes
    localparam logic [SYM_W-1:0] CH_PLUS   = 8'h2B;
    localparam logic [SYM_W-1:0] CH_MINUS  = 8'h2D;
    localparam logic [SYM_W-1:0] CH_STAR   = 8'h2A;
    localparam logic [SYM_W-1:0] CH_SLASH  = 8'h2F;
    localparam logic [SYM_W-1:0] CH_CARET  = 8'h5E;
    localparam logic [SYM_W-1:0] CH_LPAREN = 8'h28;
    localparam logic [SYM_W-1:0] CH_RPAREN = 8'h29;
    localparam logic [SYM_W-1:0] CH_ZERO   = 8'h30;

    // Result status codes
    typedef logic [STATUS_W-1:0] status_t;
    localparam status_t ST_OK    = 3'd0;
    localparam status_t ST_UNDER = 3'd1;
    localparam status_t ST_OVER  = 3'd2;
    localparam status_t ST_DIVZ  = 3'd3;
    localparam status_t ST_EMPTY = 3'd4;

    typedef enum logic [2:0] {
        OP_ADD,
        OP_SUB,
        OP_MUL,
        OP_DIV,
        OP_POW,
        OP_ONE
    } alu_op_t;

    typedef struct packed {
        logic    start;
        alu_op_t op;
    } alu_req_t;

    typedef struct packed {
        logic done;
        logic divz;
    } alu_rsp_t;

    typedef enum logic [2:0] {
        T_IDLE,
        T_RD_B,
        T_RD_A,
        T_EXEC,
        T_WAIT,
        T_FETCH,
        T_LOAD
    } top_state_t;

    typedef enum logic [2:0] {
        A_IDLE,
        A_DIV,
        A_FIX,
        A_PMUL,
        A_PSQR,
        A_DONE
    } alu_state_t;

    // True for characters that pop two operands
    function automatic logic sym_is_op(logic [SYM_W-1:0] sym);
        logic hit;
        case (sym) inside
            CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH,
            CH_CARET, CH_LPAREN, CH_RPAREN: hit = 1'b1;
            default:                        hit = 1'b0;
        endcase
        return hit;
    endfunction

    // Map an operator character to its ALU operation
    function automatic alu_op_t sym_to_op(logic [SYM_W-1:0] sym);
        alu_op_t op;
        case (sym) inside
            CH_PLUS:  op = OP_ADD;
            CH_MINUS: op = OP_SUB;
            CH_STAR:  op = OP_MUL;
            CH_SLASH: op = OP_DIV;
            CH_CARET: op = OP_POW;
            default:  op = OP_ONE;
        endcase
        return op;
    endfunction

endpackage

/* rtl/pfx_alu.sv */
// ----------------------------------------------------------------------------
// Prefix expression evaluator ALU
// Multi-cycle unit around one 32x32 multiplier: add, sub, multiply,
// restoring divide (one quotient bit per cycle), square-and-multiply
// power and the constant one used for ( ).
// ----------------------------------------------------------------------------
module pfx_alu (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  pfx_pkg::alu_req_t            req,
    input  logic [pfx_pkg::WORD_W-1:0]   b_in,
    input  logic [pfx_pkg::WORD_W-1:0]   a_in,
    output pfx_pkg::alu_rsp_t            rsp,
    output logic [pfx_pkg::WORD_W-1:0]   result
);
    import pfx_pkg::*;

    localparam int STEP_W = $clog2(WORD_W);

    alu_state_t          state_reg, state_next;
    logic [WORD_W-1:0]   res_reg;
    logic [WORD_W-1:0]   opnd_reg;   // power base or divisor magnitude
    logic [WORD_W-1:0]   work_reg;   // exponent or quotient
    logic [WORD_W-1:0]   rem_reg;
    logic [STEP_W-1:0]   step_reg;
    logic                neg_reg;
    logic                divz_reg;

    logic [WORD_W-1:0]   mul_x, mul_y, product;
    logic [WORD_W-1:0]   mag_b, mag_a;
    logic [WORD_W:0]     shifted, trial;

    assign mag_b   = b_in[WORD_W-1] ? (WORD_W'(0) - b_in) : b_in;
    assign mag_a   = a_in[WORD_W-1] ? (WORD_W'(0) - a_in) : a_in;
    assign product = mul_x * mul_y;

    // Divider step: shift in next dividend bit, trial subtract
    assign shifted = {rem_reg, work_reg[WORD_W-1]};
    assign trial   = shifted - {1'b0, opnd_reg};

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            A_IDLE: begin
                if (req.start) begin
                    if (req.op == OP_DIV && a_in != '0) begin
                        state_next = A_DIV;
                    end else if (req.op == OP_POW && !a_in[WORD_W-1] && a_in != '0) begin
                        state_next = A_PMUL;
                    end else begin
                        state_next = A_DONE;
                    end
                end
            end
            A_DIV: begin
                if (step_reg == STEP_W'(WORD_W - 1)) begin
                    state_next = A_FIX;
                end
            end
            A_FIX:  state_next = A_DONE;
            A_PMUL: state_next = A_PSQR;
            A_PSQR: begin
                if (work_reg[WORD_W-1:1] == '0) begin
                    state_next = A_DONE;
                end else begin
                    state_next = A_PMUL;
                end
            end
            A_DONE:  state_next = A_IDLE;
            default: state_next = A_IDLE;
        endcase
    end

    // Outputs and multiplier operand select
    always_comb begin
        rsp.done = (state_reg == A_DONE);
        rsp.divz = divz_reg;
        result   = res_reg;
        mul_x    = b_in;
        mul_y    = a_in;
        unique case (state_reg)
            A_PMUL: begin
                mul_x = res_reg;
                mul_y = opnd_reg;
            end
            A_PSQR: begin
                mul_x = opnd_reg;
                mul_y = opnd_reg;
            end
            default: begin
                mul_x = b_in;
                mul_y = a_in;
            end
        endcase
    end

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= A_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        case (state_reg)
            A_IDLE: begin
                if (req.start) begin
                    divz_reg <= (req.op == OP_DIV) && (a_in == '0);
                    case (req.op)
                        OP_ADD: res_reg <= b_in + a_in;
                        OP_SUB: res_reg <= b_in - a_in;
                        OP_MUL: res_reg <= product;
                        OP_DIV: begin
                            res_reg  <= '0;
                            work_reg <= mag_b;
                            opnd_reg <= mag_a;
                            rem_reg  <= '0;
                            neg_reg  <= b_in[WORD_W-1] ^ a_in[WORD_W-1];
                            step_reg <= '0;
                        end
                        OP_POW: begin
                            res_reg  <= WORD_W'(1);
                            opnd_reg <= b_in;
                            work_reg <= a_in;
                        end
                        default: res_reg <= WORD_W'(1);
                    endcase
                end
            end
            A_DIV: begin
                rem_reg  <= trial[WORD_W] ? shifted[WORD_W-1:0] : trial[WORD_W-1:0];
                work_reg <= {work_reg[WORD_W-2:0], ~trial[WORD_W]};
                step_reg <= step_reg + STEP_W'(1);
            end
            A_FIX: begin
                res_reg <= neg_reg ? (WORD_W'(0) - work_reg) : work_reg;
            end
            A_PMUL: begin
                if (work_reg[0]) begin
                    res_reg <= product;
                end
            end
            A_PSQR: begin
                opnd_reg <= product;
                work_reg <= {1'b0, work_reg[WORD_W-1:1]};
            end
            default: begin
            end
        endcase
    end

endmodule

/* rtl/prefix_expression_evaluator.sv */
// ----------------------------------------------------------------------------
// Prefix expression evaluator
// Stack machine that evaluates a prefix expression fed from its last
// character to its first, with a multi-cycle shared ALU.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: one character per request in s_tdata, s_tlast on the final
//   character fed (the first character of the expression).
//   m_ channel: one result per expression, value in m_tdata and status in
//   m_tuser (0 ok, 1 underflow, 2 overflow, 3 divide by zero, 4 empty).
//   A digit is pushed as it is taken. An operator reads its two operands
//   (T_RD_B, T_RD_A), starts the shared ALU (T_EXEC) and waits for it
//   (T_WAIT); / iterates over 32 divider steps and ^ makes two multiplier
//   passes per exponent bit. The final character then goes through
//   T_FETCH to read the top of stack and T_LOAD to load the output
//   register. s_tready is low while a character is being worked on.
//   The output register holds a result until m_tready; the block keeps
//   taking characters meanwhile and waits only if a second result is ready.
//   Reset empties the stack, clears the status and drops the output valid;
//   no memory clearing pass is needed.
// ----------------------------------------------------------------------------
module prefix_expression_evaluator #(
    parameter int STACK_DEPTH = pfx_pkg::STACK_DEPTH_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [pfx_pkg::SYM_W-1:0]      s_tdata,   // [7:0] symbol
    input  logic                           s_tlast,   // last_symbol
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [pfx_pkg::WORD_W-1:0]     m_tdata,   // [31:0] value
    output logic [pfx_pkg::STATUS_W-1:0]   m_tuser    // [2:0] status
);
    import pfx_pkg::*;

    localparam int IDX_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CNT_W = $clog2(STACK_DEPTH + 1);

    top_state_t          state_reg, state_next;
    logic [CNT_W-1:0]    cnt_reg;
    status_t             err_reg;
    alu_op_t             op_reg;
    logic                last_reg;
    logic [WORD_W-1:0]   b_reg;
    logic [WORD_W-1:0]   rd_data_reg;
    logic                m_valid_reg;
    logic [WORD_W-1:0]   m_data_reg;
    status_t             m_status_reg;

    logic [WORD_W-1:0]   stack_mem [STACK_DEPTH];

    logic                accept;
    logic                in_is_op;
    logic [WORD_W-1:0]   push_word;
    logic [CNT_W-1:0]    cnt_m1, cnt_m2;
    logic                has_room, has_two, out_free;
    logic                wr_en;
    logic [IDX_W-1:0]    wr_addr, rd_addr;
    logic [WORD_W-1:0]   wr_data;
    alu_req_t            alu_req;
    alu_rsp_t            alu_rsp;
    logic [WORD_W-1:0]   alu_result;
    status_t             end_status;

    assign accept    = s_tvalid && s_tready;
    assign in_is_op  = sym_is_op(s_tdata);
    assign push_word = {{(WORD_W - SYM_W){1'b0}}, s_tdata} - WORD_W'(CH_ZERO);
    assign cnt_m1    = cnt_reg - CNT_W'(1);
    assign cnt_m2    = cnt_reg - CNT_W'(2);
    assign has_room  = (cnt_reg < CNT_W'(STACK_DEPTH));
    assign has_two   = (cnt_reg >= CNT_W'(2));
    assign out_free  = !m_valid_reg || m_tready;

    // Final status: first recorded error wins, else empty or ok
    always_comb begin
        if (err_reg != ST_OK) begin
            end_status = err_reg;
        end else if (cnt_reg == '0) begin
            end_status = ST_EMPTY;
        end else begin
            end_status = ST_OK;
        end
    end

    pfx_alu u_alu (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (alu_req),
        .b_in    (b_reg),
        .a_in    (rd_data_reg),
        .rsp     (alu_rsp),
        .result  (alu_result)
    );

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            T_IDLE: begin
                if (accept) begin
                    if (in_is_op && has_two) begin
                        state_next = T_RD_B;
                    end else if (s_tlast) begin
                        state_next = T_FETCH;
                    end
                end
            end
            T_RD_B:  state_next = T_RD_A;
            T_RD_A:  state_next = T_EXEC;
            T_EXEC:  state_next = T_WAIT;
            T_WAIT: begin
                if (alu_rsp.done) begin
                    state_next = last_reg ? T_FETCH : T_IDLE;
                end
            end
            T_FETCH: state_next = T_LOAD;
            T_LOAD: begin
                if (out_free) begin
                    state_next = T_IDLE;
                end
            end
            default: state_next = T_IDLE;
        endcase
    end

    // Control outputs: handshake, stack ports, ALU request
    always_comb begin
        s_tready      = 1'b0;
        rd_addr       = cnt_m1[IDX_W-1:0];
        wr_en         = 1'b0;
        wr_addr       = cnt_reg[IDX_W-1:0];
        wr_data       = push_word;
        alu_req.start = 1'b0;
        alu_req.op    = op_reg;
        unique case (state_reg)
            T_IDLE: begin
                s_tready = 1'b1;
                wr_en    = accept && !in_is_op && has_room;
            end
            T_RD_A: rd_addr = cnt_m2[IDX_W-1:0];
            T_EXEC: alu_req.start = 1'b1;
            T_WAIT: begin
                wr_en   = alu_rsp.done;
                wr_addr = cnt_m2[IDX_W-1:0];
                wr_data = alu_result;
            end
            default: begin
            end
        endcase
    end

    // Operand stack: one write and one registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            stack_mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= stack_mem[rd_addr];
    end

    // Operand and operation capture
    always_ff @(posedge aclk) begin
        if (state_reg == T_IDLE && accept) begin
            op_reg   <= sym_to_op(s_tdata);
            last_reg <= s_tlast;
        end
        if (state_reg == T_RD_A) begin
            b_reg <= rd_data_reg;
        end
        if (state_reg == T_LOAD && out_free) begin
            m_data_reg   <= (cnt_reg != '0) ? rd_data_reg : '0;
            m_status_reg <= end_status;
        end
    end

    // Control registers: state, stack count, sticky error, output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= T_IDLE;
            cnt_reg     <= '0;
            err_reg     <= ST_OK;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            // Drop an accepted result unless a new one loads in its place
            if (m_valid_reg && m_tready && state_reg != T_LOAD) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                T_IDLE: begin
                    if (accept) begin
                        if (in_is_op) begin
                            if (!has_two && err_reg == ST_OK) begin
                                err_reg <= ST_UNDER;
                            end
                        end else if (has_room) begin
                            cnt_reg <= cnt_reg + CNT_W'(1);
                        end else if (err_reg == ST_OK) begin
                            err_reg <= ST_OVER;
                        end
                    end
                end
                T_WAIT: begin
                    // Drop two operands, push one result
                    if (alu_rsp.done) begin
                        cnt_reg <= cnt_m1;
                        if (alu_rsp.divz && err_reg == ST_OK) begin
                            err_reg <= ST_DIVZ;
                        end
                    end
                end
                T_LOAD: begin
                    if (out_free) begin
                        m_valid_reg <= 1'b1;
                        cnt_reg     <= '0;
                        err_reg     <= ST_OK;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_status_reg;

endmodule

/* rtl/pfx_checker.sv */
// ----------------------------------------------------------------------------
// Prefix expression evaluator port checker
// Watches the stream ports of the top level and flags protocol or result
// slips; bound to every instance of the top level.
// ----------------------------------------------------------------------------
`include "prefix_expression_evaluator_defines.svh"

module pfx_checker (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    input  logic                           s_tlast,
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic [pfx_pkg::WORD_W-1:0]     m_tdata,
    input  logic [pfx_pkg::STATUS_W-1:0]   m_tuser
);
    import pfx_pkg::*;

    // Hold a stalled result
    `PFX_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))

    // Status stays within its defined codes
    `PFX_ASSERT_IMPL(a_status_range, aclk, aresetn, m_tvalid, m_tuser <= ST_EMPTY)

    // An empty stack at the end reports a zero value
    `PFX_ASSERT_IMPL(a_empty_zero, aclk, aresetn, m_tvalid && (m_tuser == ST_EMPTY), m_tdata == '0)

    // A character that does not end an expression never raises a result
    `PFX_ASSERT_NEXT(a_no_early_result, aclk, aresetn, s_tvalid && s_tready && !s_tlast, !$rose(m_tvalid))

endmodule

bind prefix_expression_evaluator pfx_checker u_pfx_checker (.*);
